### hw/rtl/serial_packet_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// Serial packet deframer assertion macros
// Shared assertion wrappers for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef SERIAL_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define SERIAL_PACKET_DEFRAMER_UNIT_MACROS_SVH

// Clocked check, switched off while reset is held
`define SPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define SPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### hw/rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// Serial packet deframer package
// Frame constants, store geometry and the modulo-255 running sum.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

    localparam int unsigned MAX_PAYLOAD  = 64;
    localparam int unsigned HIGHEST_PORT = 15;
    localparam int unsigned STORE_DEPTH  = 64;
    localparam int unsigned ADDR_W       = $clog2(STORE_DEPTH);
    localparam int unsigned MASK_W       = 16;

    localparam logic [7:0] START_FIRST  = 8'hAA;
    localparam logic [7:0] START_SECOND = 8'hBB;
    localparam logic [7:0] SUM_MODULUS  = 8'hFF;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    // (sum + b) mod 255; the sum may enter as 255 straight after the sequence byte
    function automatic logic [7:0] add_mod(input logic [7:0] sum, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, sum} + {1'b0, b};
        if (s >= {SUM_MODULUS, 1'b0}) begin
            add_mod = 8'h00;
        end else if (s >= {1'b0, SUM_MODULUS}) begin
            add_mod = 8'(s - {1'b0, SUM_MODULUS});
        end else begin
            add_mod = s[7:0];
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/spd_store.sv
// ----------------------------------------------------------------------------
// Payload store
// Single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_store (
    input  wire                         i_clk,
    input  wire  spd_pkg::t_wr_req      i_wr,
    input  wire                         i_rd_en,
    input  wire  [spd_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [7:0]                  o_rd_data
);
    import spd_pkg::*;

    logic [7:0] r_mem [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/serial_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// Serial packet deframer
// Byte-stream receive deframer: start hunt, header checks, payload buffering
// and packet replay with checksum flag.
// ----------------------------------------------------------------------------
// Bytes of a frame (0xAA 0xBB, sequence, port, size, payload, checksum) are
// taken one per cycle. Payload bytes go into a 64-entry store. A port above
// 15 or with a clear bit in the port enable mask, or a size of 64 or more,
// drops the frame and hunting starts afresh; a mismatching start byte is not
// rechecked as a first start byte. When the checksum byte is taken the block
// stops taking input and replays the packet from the store, one result per
// payload byte (one result with payload_valid low for an empty packet), each
// carrying the header and a checksum_ok flag; the running sum begins at the
// sequence byte and adds every later header and payload byte modulo 255.
// Rate: one input byte per cycle outside replay. Each replay result passes
// through a store read state and then an output load state, as the store has
// a single read port, and the load waits out any output stall; input is held
// off until the last result is loaded. The output register lets the last
// result wait while the next frame is already being taken. Configuration
// writes to the mask are taken in any cycle and should arrive while idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_packet_deframer_unit_macros.svh"

module serial_packet_deframer_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration
    input  wire                          i_cfg_we,
    input  wire  [spd_pkg::MASK_W-1:0]   i_cfg_wdata,
    // receive byte channel
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [7:0]                   i_rx_byte,
    // packet result channel
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [7:0]                   o_seq_number,
    output logic [3:0]                   o_port_number,
    output logic [5:0]                   o_payload_size,
    output logic [5:0]                   o_byte_index,
    output logic [7:0]                   o_payload_byte,
    output logic                         o_payload_valid,
    output logic                         o_last_of_packet,
    output logic                         o_checksum_ok
);
    import spd_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_SEQ,
        PH_PORT,
        PH_SIZE,
        PH_DATA,
        PH_CHECK,
        PH_EMIT_RD,
        PH_EMIT_LD
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [7:0]        r_seq, n_seq;
    logic [3:0]        r_port, n_port;
    logic [5:0]        r_size, n_size;
    logic [7:0]        r_sum, n_sum;
    logic              r_ok, n_ok;
    logic [MASK_W-1:0] r_mask;

    // output register
    logic       r_o_valid, n_o_valid;
    logic [7:0] r_o_seq, n_o_seq;
    logic [3:0] r_o_port, n_o_port;
    logic [5:0] r_o_size, n_o_size;
    logic [5:0] r_o_index, n_o_index;
    logic [7:0] r_o_byte, n_o_byte;
    logic       r_o_pvalid, n_o_pvalid;
    logic       r_o_last, n_o_last;
    logic       r_o_ok, n_o_ok;

    t_wr_req     w_wr;
    logic        w_rd_en;
    logic [7:0]  w_rd_data;
    logic        w_take;
    logic        w_out_free;
    logic        w_empty;
    logic        w_last;
    logic [ADDR_W-1:0] w_pos_inc;

    spd_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_pos),
        .o_rd_data (w_rd_data)
    );

    assign o_in_stall = (r_phase == PH_EMIT_RD) || (r_phase == PH_EMIT_LD);
    assign w_take     = i_in_valid && !o_in_stall;
    assign w_out_free = !r_o_valid || !i_out_stall;
    assign w_empty    = (r_size == 6'd0);
    assign w_last     = w_empty || ({1'b0, r_pos} + 7'd1 == {1'b0, r_size});
    assign w_pos_inc  = r_pos + ADDR_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_seq      = r_seq;
        n_port     = r_port;
        n_size     = r_size;
        n_sum      = r_sum;
        n_ok       = r_ok;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_seq    = r_o_seq;
        n_o_port   = r_o_port;
        n_o_size   = r_o_size;
        n_o_index  = r_o_index;
        n_o_byte   = r_o_byte;
        n_o_pvalid = r_o_pvalid;
        n_o_last   = r_o_last;
        n_o_ok     = r_o_ok;
        w_wr.we    = 1'b0;
        w_wr.addr  = r_pos;
        w_wr.data  = i_rx_byte;
        w_rd_en    = 1'b0;

        case (r_phase)
            PH_START: begin
                if (w_take) begin
                    if (r_pos == '0) begin
                        if (i_rx_byte == START_FIRST) begin
                            n_pos = ADDR_W'(1);
                        end
                    end else begin
                        n_pos = '0;
                        if (i_rx_byte == START_SECOND) begin
                            n_phase = PH_SEQ;
                        end
                    end
                end
            end
            PH_SEQ: begin
                if (w_take) begin
                    n_seq   = i_rx_byte;
                    n_sum   = i_rx_byte;
                    n_phase = PH_PORT;
                end
            end
            PH_PORT: begin
                if (w_take) begin
                    if (i_rx_byte > 8'(HIGHEST_PORT) || i_rx_byte >= 8'(MASK_W) ||
                        !r_mask[i_rx_byte[3:0]]) begin
                        n_phase = PH_START;
                        n_pos   = '0;
                    end else begin
                        n_port  = i_rx_byte[3:0];
                        n_sum   = add_mod(r_sum, i_rx_byte);
                        n_phase = PH_SIZE;
                    end
                end
            end
            PH_SIZE: begin
                if (w_take) begin
                    n_pos = '0;
                    if ({1'b0, i_rx_byte} < 9'(MAX_PAYLOAD) &&
                        {1'b0, i_rx_byte} < 9'(STORE_DEPTH)) begin
                        n_size  = i_rx_byte[5:0];
                        n_sum   = add_mod(r_sum, i_rx_byte);
                        n_phase = (i_rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                    end else begin
                        n_phase = PH_START;
                    end
                end
            end
            PH_DATA: begin
                if (w_take) begin
                    w_wr.we = 1'b1;
                    n_sum   = add_mod(r_sum, i_rx_byte);
                    if (6'(w_pos_inc) >= r_size) begin
                        n_pos   = '0;
                        n_phase = PH_CHECK;
                    end else begin
                        n_pos = w_pos_inc;
                    end
                end
            end
            PH_CHECK: begin
                if (w_take) begin
                    n_ok    = (i_rx_byte == r_sum);
                    n_pos   = '0;
                    n_phase = PH_EMIT_RD;
                end
            end
            PH_EMIT_RD: begin
                w_rd_en = 1'b1;
                n_phase = PH_EMIT_LD;
            end
            PH_EMIT_LD: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_seq    = r_seq;
                    n_o_port   = r_port;
                    n_o_size   = r_size;
                    n_o_index  = 6'(r_pos);
                    n_o_byte   = w_empty ? 8'd0 : w_rd_data;
                    n_o_pvalid = !w_empty;
                    n_o_last   = w_last;
                    n_o_ok     = r_ok;
                    if (w_last) begin
                        n_pos   = '0;
                        n_phase = PH_START;
                    end else begin
                        n_pos   = w_pos_inc;
                        n_phase = PH_EMIT_RD;
                    end
                end
            end
            default: begin
                n_phase = PH_START;
                n_pos   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_pos     <= '0;
            r_seq     <= '0;
            r_port    <= '0;
            r_size    <= '0;
            r_sum     <= '0;
            r_mask    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_seq     <= n_seq;
            r_port    <= n_port;
            r_size    <= n_size;
            r_sum     <= n_sum;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
        end
        r_ok       <= n_ok;
        r_o_seq    <= n_o_seq;
        r_o_port   <= n_o_port;
        r_o_size   <= n_o_size;
        r_o_index  <= n_o_index;
        r_o_byte   <= n_o_byte;
        r_o_pvalid <= n_o_pvalid;
        r_o_last   <= n_o_last;
        r_o_ok     <= n_o_ok;
    end

    assign o_out_valid      = r_o_valid;
    assign o_seq_number     = r_o_seq;
    assign o_port_number    = r_o_port;
    assign o_payload_size   = r_o_size;
    assign o_byte_index     = r_o_index;
    assign o_payload_byte   = r_o_byte;
    assign o_payload_valid  = r_o_pvalid;
    assign o_last_of_packet = r_o_last;
    assign o_checksum_ok    = r_o_ok;

    // replay finishes by returning to the start hunt
    `SPD_ASSERT(a_replay_end, (r_phase == PH_EMIT_LD && w_out_free && w_last) |=> (r_phase == PH_START), "replay did not return to start hunt")
    // data results stay inside the packet
    `SPD_ASSERT(a_index_range, (o_out_valid && o_payload_valid) |-> (o_byte_index < o_payload_size), "byte index beyond payload size")
    // last flag lands on the final payload byte
    `SPD_ASSERT(a_last_pos, (o_out_valid && o_payload_valid && o_last_of_packet) |-> ({1'b0, o_byte_index} + 7'd1 == {1'b0, o_payload_size}), "last flag on wrong byte")
    // sum has been reduced below 255 by the time the checksum arrives
    `SPD_ASSERT(a_sum_reduced, (r_phase == PH_CHECK) |-> (r_sum != SUM_MODULUS), "running sum not reduced")

endmodule

`default_nettype wire
